[design/mcvs_pkg.sv]
// ----------------------------------------------------------------------------
// mcvs_pkg
// Shared constants, codes and types of the multi-channel value sweeper.
// ----------------------------------------------------------------------------
package mcvs_pkg;

	// table geometry
	localparam int ENTRIES       = 8;
	localparam int VALUE_BITS    = 16;
	localparam int IDX_BITS      = 3;
	localparam int MODE_BITS     = 3;
	localparam int PERIOD_BITS   = 16;
	localparam int STEP_BITS     = 8;
	localparam int REQ_BITS      = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IDX_BITS-1:0] LAST_ENTRY = IDX_BITS'(ENTRIES - 1);

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_LOAD    = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_RESTART = 2'd2;

	// sweep modes
	localparam logic [MODE_BITS-1:0] MODE_OFF         = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_LOOP_UP     = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_LOOP_DOWN   = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_LOOP_UPDOWN = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_ONCE_UP     = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_ONCE_DOWN   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_MODE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICK_PERIOD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE   = 2'd2;

	// entry direction
	typedef enum logic [1:0] {
		DIR_UP   = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_DONE = 2'd2
	} dir_t;

	// configuration seen by front and back
	typedef struct packed {
		logic [MODE_BITS-1:0]   mode;
		logic [PERIOD_BITS-1:0] period;
		logic [STEP_BITS-1:0]   step;
	} cfg_t;

	// classified command handed from front to back
	typedef struct packed {
		logic                  fired;
		logic                  sweep;
		logic                  load;
		logic                  restart;
		logic [IDX_BITS-1:0]   index;
		logic                  used;
		logic [VALUE_BITS-1:0] low;
		logic [VALUE_BITS-1:0] high;
		logic [VALUE_BITS-1:0] start;
	} cmd_t;

endpackage

[design/mcvs_front.sv]
// ----------------------------------------------------------------------------
// mcvs_front
// Accepts input beats, runs the tick prescaler and classifies each beat
// into a command for the back end.
// ----------------------------------------------------------------------------
module mcvs_front import mcvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_BITS-1:0]   req_type,
	input  logic [IDX_BITS-1:0]   entry_index,
	input  logic                  entry_used,
	input  logic [VALUE_BITS-1:0] range_low,
	input  logic [VALUE_BITS-1:0] range_high,
	input  logic [VALUE_BITS-1:0] start_value,
	output logic                  push_valid,
	input  logic                  push_ready,
	output cmd_t                  push_cmd
);

	logic [PERIOD_BITS-1:0] prescale_q;
	logic                   tick_on;
	logic                   fire;

	// a tick only counts while the sweeper is on
	assign tick_on = (req_type == REQ_TICK) && (cfg.mode != MODE_OFF);
	assign fire    = tick_on && (prescale_q >= cfg.period);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// command build
	always_comb begin
		push_cmd         = '0;
		push_cmd.fired   = fire;
		push_cmd.sweep   = fire && (cfg.step != '0);
		push_cmd.load    = (req_type == REQ_LOAD);
		push_cmd.restart = (req_type == REQ_RESTART);
		push_cmd.index   = entry_index;
		push_cmd.used    = entry_used;
		push_cmd.low     = range_low;
		push_cmd.high    = range_high;
		push_cmd.start   = start_value;
	end

	// prescaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
		end else if (in_valid && in_ready && tick_on) begin
			if (fire) begin
				prescale_q <= '0;
			end else begin
				prescale_q <= prescale_q + 1'b1;
			end
		end
	end

endmodule

[design/mcvs_queue.sv]
// ----------------------------------------------------------------------------
// mcvs_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mcvs_queue import mcvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill level stays within depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue fill level beyond depth");

	// an empty queue stays empty without a push
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) && !push_valid |=> (count_q == '0))
		else $error("queue filled without a push");

endmodule

[design/mcvs_back.sv]
// ----------------------------------------------------------------------------
// mcvs_back
// Holds the entry table and carries out each command by walking the entries
// one per cycle while the output is not stalled, one result beat per entry.
// ----------------------------------------------------------------------------
module mcvs_back import mcvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  cmd_t                  pop_cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_BITS-1:0]   out_entry,
	output logic [VALUE_BITS-1:0] out_value,
	output logic                  value_written,
	output logic                  tick_fired,
	output logic                  last_result
);

	// entry table
	logic [VALUE_BITS-1:0] value_q  [ENTRIES];
	logic [VALUE_BITS-1:0] low_q    [ENTRIES];
	logic [VALUE_BITS-1:0] high_q   [ENTRIES];
	logic                  active_q [ENTRIES];
	dir_t                  dir_q    [ENTRIES];

	// walk control
	cmd_t                cmd_q;
	logic                busy_q;
	logic [IDX_BITS-1:0] pos_q;
	logic                step_go;
	logic                last_step;

	// output register
	logic                  out_valid_q;
	logic [IDX_BITS-1:0]   out_entry_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  written_q;
	logic                  fired_q;
	logic                  last_q;

	// per-entry datapath
	logic [VALUE_BITS-1:0] cur_v;
	logic [VALUE_BITS-1:0] cur_lo;
	logic [VALUE_BITS-1:0] cur_hi;
	logic                  cur_act;
	dir_t                  cur_dir;
	logic [VALUE_BITS:0]   sum_w;
	logic [VALUE_BITS-1:0] diff_w;
	logic [VALUE_BITS-1:0] step_w;
	logic                  over;
	logic                  below;
	logic                  once;
	logic [VALUE_BITS-1:0] nxt_v;
	logic [VALUE_BITS-1:0] nxt_lo;
	logic [VALUE_BITS-1:0] nxt_hi;
	logic                  nxt_act;
	dir_t                  nxt_dir;
	logic                  nxt_wr;

	assign step_go   = busy_q && (!out_valid_q || out_ready);
	assign last_step = step_go && (pos_q == LAST_ENTRY);
	assign pop_ready = !busy_q || last_step;

	assign cur_v   = value_q[pos_q];
	assign cur_lo  = low_q[pos_q];
	assign cur_hi  = high_q[pos_q];
	assign cur_act = active_q[pos_q];
	assign cur_dir = dir_q[pos_q];

	// bound checks on the exact sum and difference
	assign step_w = VALUE_BITS'(cfg.step);
	assign sum_w  = {1'b0, cur_v} + {1'b0, step_w};
	assign diff_w = cur_v - step_w;
	assign over   = sum_w > {1'b0, cur_hi};
	assign below  = (cur_v < step_w) || (diff_w < cur_lo);
	assign once   = (cfg.mode == MODE_ONCE_UP) || (cfg.mode == MODE_ONCE_DOWN);

	// next state of the current entry
	always_comb begin
		nxt_v   = cur_v;
		nxt_lo  = cur_lo;
		nxt_hi  = cur_hi;
		nxt_act = cur_act;
		nxt_dir = cur_dir;
		nxt_wr  = 1'b0;
		if (cmd_q.load && (cmd_q.index == pos_q)) begin
			nxt_act = cmd_q.used;
			nxt_lo  = cmd_q.low;
			nxt_hi  = cmd_q.high;
			nxt_v   = cmd_q.start;
		end
		if (cmd_q.restart) begin
			if ((cfg.mode == MODE_ONCE_DOWN) || (cfg.mode == MODE_LOOP_DOWN)) begin
				nxt_dir = DIR_DOWN;
			end else begin
				nxt_dir = DIR_UP;
			end
		end
		if (cmd_q.sweep && cur_act && !(once && (cur_dir == DIR_DONE))) begin
			nxt_wr = 1'b1;
			if (cur_dir == DIR_UP) begin
				nxt_v = sum_w[VALUE_BITS-1:0];
				if (over) begin
					if (cfg.mode == MODE_ONCE_UP) begin
						nxt_dir = DIR_DONE;
						nxt_v   = cur_v;
						nxt_wr  = 1'b0;
					end else if (cfg.mode == MODE_LOOP_UP) begin
						nxt_v = cur_lo;
					end else if ((cfg.mode == MODE_LOOP_UPDOWN) ||
					             (cfg.mode == MODE_LOOP_DOWN)) begin
						nxt_dir = DIR_DOWN;
						nxt_v   = cur_hi;
					end
				end
			end else begin
				// done entries outside the once modes move down
				nxt_v = diff_w;
				if (below) begin
					if (cfg.mode == MODE_ONCE_DOWN) begin
						nxt_dir = DIR_DONE;
						nxt_v   = cur_v;
						nxt_wr  = 1'b0;
					end else if (cfg.mode == MODE_LOOP_DOWN) begin
						nxt_v = cur_hi;
					end else if ((cfg.mode == MODE_LOOP_UPDOWN) ||
					             (cfg.mode == MODE_LOOP_UP)) begin
						nxt_dir = DIR_UP;
						nxt_v   = cur_lo;
					end
				end
			end
		end
	end

	// entry table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				value_q[i]  <= '0;
				low_q[i]    <= '0;
				high_q[i]   <= '0;
				active_q[i] <= 1'b0;
				dir_q[i]    <= DIR_UP;
			end
		end else if (step_go) begin
			value_q[pos_q]  <= nxt_v;
			low_q[pos_q]    <= nxt_lo;
			high_q[pos_q]   <= nxt_hi;
			active_q[pos_q] <= nxt_act;
			dir_q[pos_q]    <= nxt_dir;
		end
	end

	// command pickup
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cmd_q <= pop_cmd;
		end
	end

	// walk over the entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (step_go) begin
				pos_q <= (pos_q == LAST_ENTRY) ? '0 : pos_q + 1'b1;
			end
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
			end else if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			out_entry_q <= pos_q;
			out_value_q <= nxt_v;
			written_q   <= nxt_wr;
			fired_q     <= cmd_q.fired;
			last_q      <= (pos_q == LAST_ENTRY);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_entry     = out_entry_q;
	assign out_value     = out_value_q;
	assign value_written = written_q;
	assign tick_fired    = fired_q;
	assign last_result   = last_q;

	// last beat flag follows the final entry
	a_last_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == (out_entry_q == LAST_ENTRY)))
		else $error("last_result out of step with entry");

	// a value is only written on a firing tick
	a_write_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && written_q |-> fired_q)
		else $error("value written without a firing tick");

	// the walk always starts at the first entry
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pos_q == '0))
		else $error("walk position not at first entry while idle");

endmodule

[design/multi_channel_value_sweeper_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_value_sweeper_unit
// Sawtooth / triangle sweep generator over a table of eight entries, with a
// front end that classifies requests and a back end that walks the table.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     req_type entry_index entry_used range_low
//                                   range_high start_value
//  out      out_valid / out_ready   out_entry out_value value_written
//                                   tick_fired last_result
//  cfg      cfg_write               cfg_index cfg_data
//
// Every input beat yields eight result beats, one per entry in order.
// The back end walks one entry per cycle while the output is not stalled;
// a command that reaches an empty queue needs a pickup step before its walk.
// A two-deep command queue lets the front accept while the back is busy.
// Output stalls hold the walk; reset clears the table, prescaler and config.
// ----------------------------------------------------------------------------
module multi_channel_value_sweeper_unit import mcvs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [REQ_BITS-1:0]      req_type,
	input  logic [IDX_BITS-1:0]      entry_index,
	input  logic                     entry_used,
	input  logic [VALUE_BITS-1:0]    range_low,
	input  logic [VALUE_BITS-1:0]    range_high,
	input  logic [VALUE_BITS-1:0]    start_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_BITS-1:0]      out_entry,
	output logic [VALUE_BITS-1:0]    out_value,
	output logic                     value_written,
	output logic                     tick_fired,
	output logic                     last_result
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SWEEP_MODE:  cfg_q.mode   <= cfg_data[MODE_BITS-1:0];
				REG_TICK_PERIOD: cfg_q.period <= cfg_data[PERIOD_BITS-1:0];
				REG_STEP_SIZE:   cfg_q.step   <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	mcvs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_used  (entry_used),
		.range_low   (range_low),
		.range_high  (range_high),
		.start_value (start_value),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	mcvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	mcvs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_cmd       (pop_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_entry     (out_entry),
		.out_value     (out_value),
		.value_written (value_written),
		.tick_fired    (tick_fired),
		.last_result   (last_result)
	);

endmodule

[tb/tb_multi_channel_value_sweeper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_value_sweeper_unit
// Self-checking bench for the sweep generator. Requests are queued by a
// stimulus process, driven by a clocked driver with random gaps and mirrored
// into a behavioural table model on acceptance; each accepted request expects
// one report per entry. A clocked monitor with random back-pressure compares
// every report beat with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_multi_channel_value_sweeper_unit;
	import mcvs_pkg::*;

	// request code with no defined action, and the two spare sweep modes
	localparam logic [REQ_BITS-1:0]  REQ_UNUSED  = 2'd3;
	localparam logic [MODE_BITS-1:0] MODE_RSVD6  = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_RSVD7  = 3'd7;
	localparam int                   LONG_HOLD_AT = 600;
	localparam int                   LONG_HOLD_LEN = 300;

	typedef struct {
		logic [REQ_BITS-1:0]   kind;
		logic [IDX_BITS-1:0]   index;
		logic                  used;
		logic [VALUE_BITS-1:0] low;
		logic [VALUE_BITS-1:0] high;
		logic [VALUE_BITS-1:0] start;
	} sweep_request_t;

	typedef struct {
		logic [IDX_BITS-1:0]   entry;
		logic [VALUE_BITS-1:0] value;
		logic                  written;
		logic                  fired;
		logic                  last;
	} entry_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [REQ_BITS-1:0]      req_type = '0;
	logic [IDX_BITS-1:0]      entry_index = '0;
	logic                     entry_used = 1'b0;
	logic [VALUE_BITS-1:0]    range_low = '0;
	logic [VALUE_BITS-1:0]    range_high = '0;
	logic [VALUE_BITS-1:0]    start_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_BITS-1:0]      out_entry;
	logic [VALUE_BITS-1:0]    out_value;
	logic                     value_written;
	logic                     tick_fired;
	logic                     last_result;

	multi_channel_value_sweeper_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.entry_index   (entry_index),
		.entry_used    (entry_used),
		.range_low     (range_low),
		.range_high    (range_high),
		.start_value   (start_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_entry     (out_entry),
		.out_value     (out_value),
		.value_written (value_written),
		.tick_fired    (tick_fired),
		.last_result   (last_result)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table model state and its copy of the registers
	logic [MODE_BITS-1:0]   mode_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [PERIOD_BITS-1:0] prescale_q;
	logic [VALUE_BITS-1:0]  value_tbl [ENTRIES];
	logic [VALUE_BITS-1:0]  low_tbl [ENTRIES];
	logic [VALUE_BITS-1:0]  high_tbl [ENTRIES];
	logic                   used_tbl [ENTRIES];
	dir_t                   dir_tbl [ENTRIES];

	sweep_request_t request_queue [$];
	entry_report_t  expected_reports [$];
	logic           item_live = 1'b0;
	logic           gapless = 1'b0;
	int             send_gap = 0;
	int             rx_stall = 0;
	int             long_hold = 0;
	logic           long_hold_done = 1'b0;
	int             beats_seen = 0;
	int             error_count = 0;

	task automatic clear_table;
		mode_q = MODE_OFF;
		period_q = '0;
		step_q = '0;
		prescale_q = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			value_tbl[i] = '0;
			low_tbl[i] = '0;
			high_tbl[i] = '0;
			used_tbl[i] = 1'b0;
			dir_tbl[i] = DIR_UP;
		end
	endtask

	// move one entry by the step; bounds judged on the unwrapped sum
	task automatic step_entry(input int i, output logic wrote);
		logic [VALUE_BITS:0]   sum;
		logic [VALUE_BITS-1:0] nv;
		logic [VALUE_BITS-1:0] step_ext;
		logic                  below;
		logic                  once;
		step_ext = step_q;
		once = (mode_q == MODE_ONCE_UP) || (mode_q == MODE_ONCE_DOWN);
		wrote = 1'b0;
		if (!(once && dir_tbl[i] == DIR_DONE) && used_tbl[i]) begin
			wrote = 1'b1;
			if (dir_tbl[i] == DIR_UP) begin
				sum = value_tbl[i] + step_ext;
				nv = sum[VALUE_BITS-1:0];
				if (sum > {1'b0, high_tbl[i]}) begin
					case (mode_q)
						MODE_ONCE_UP: begin
							dir_tbl[i] = DIR_DONE;
							wrote = 1'b0;
						end
						MODE_LOOP_UP: nv = low_tbl[i];
						MODE_LOOP_DOWN, MODE_LOOP_UPDOWN: begin
							dir_tbl[i] = DIR_DOWN;
							nv = high_tbl[i];
						end
						default: ;
					endcase
				end
			end else begin
				// done entries outside the once modes fall through to here
				below = (value_tbl[i] < step_ext) || (value_tbl[i] - step_ext < low_tbl[i]);
				nv = value_tbl[i] - step_ext;
				if (below) begin
					case (mode_q)
						MODE_ONCE_DOWN: begin
							dir_tbl[i] = DIR_DONE;
							wrote = 1'b0;
						end
						MODE_LOOP_DOWN: nv = high_tbl[i];
						MODE_LOOP_UP, MODE_LOOP_UPDOWN: begin
							dir_tbl[i] = DIR_UP;
							nv = low_tbl[i];
						end
						default: ;
					endcase
				end
			end
			if (wrote)
				value_tbl[i] = nv;
		end
	endtask

	// apply one accepted request and queue the eight reports it causes
	task automatic sweep_item(input sweep_request_t rq);
		logic          written [ENTRIES];
		logic          fired;
		dir_t          new_dir;
		entry_report_t rp;
		fired = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			written[i] = 1'b0;
		case (rq.kind)
			REQ_TICK: begin
				if (mode_q != MODE_OFF) begin
					if (prescale_q < period_q) begin
						prescale_q = prescale_q + 1'b1;
					end else begin
						prescale_q = '0;
						fired = 1'b1;
						if (step_q != '0) begin
							for (int i = 0; i < ENTRIES; i++)
								step_entry(i, written[i]);
						end
					end
				end
			end
			REQ_LOAD: begin
				used_tbl[rq.index] = rq.used;
				low_tbl[rq.index] = rq.low;
				high_tbl[rq.index] = rq.high;
				value_tbl[rq.index] = rq.start;
			end
			REQ_RESTART: begin
				new_dir = (mode_q == MODE_ONCE_DOWN || mode_q == MODE_LOOP_DOWN) ? DIR_DOWN : DIR_UP;
				for (int i = 0; i < ENTRIES; i++)
					dir_tbl[i] = new_dir;
			end
			default: ;
		endcase
		for (int i = 0; i < ENTRIES; i++) begin
			rp.entry = IDX_BITS'(i);
			rp.value = value_tbl[i];
			rp.written = written[i];
			rp.fired = fired;
			rp.last = (i == ENTRIES - 1);
			expected_reports.push_back(rp);
		end
	endtask

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (gapless || r < 65)
			pick_gap = 0;
		else if (r < 92)
			pick_gap = $urandom_range(1, 3);
		else
			pick_gap = $urandom_range(8, 40);
	endfunction

	// load with bounds near the bottom, near the top or anywhere
	function automatic sweep_request_t random_load(input logic [IDX_BITS-1:0] idx);
		sweep_request_t rq;
		int unsigned    lo;
		int unsigned    hi;
		rq.kind = REQ_LOAD;
		rq.index = idx;
		rq.used = ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 3))
			0: lo = $urandom_range(0, 300);
			1: lo = $urandom_range(63000, 65535);
			default: lo = $urandom_range(0, 65535);
		endcase
		hi = lo + $urandom_range(0, 2500);
		if (hi > 65535)
			hi = 65535;
		rq.low = VALUE_BITS'(lo);
		rq.high = VALUE_BITS'(hi);
		rq.start = VALUE_BITS'(lo + $urandom_range(0, hi - lo));
		// now and then fully arbitrary, low above high included
		if ($urandom_range(0, 9) == 0) begin
			rq.low = VALUE_BITS'($urandom);
			rq.high = VALUE_BITS'($urandom);
			rq.start = VALUE_BITS'($urandom);
		end
		random_load = rq;
	endfunction

	function automatic sweep_request_t random_request();
		sweep_request_t rq;
		int unsigned    pick;
		pick = $urandom_range(0, 99);
		rq = random_load(IDX_BITS'($urandom_range(0, ENTRIES - 1)));
		if (pick < 64)
			rq.kind = REQ_TICK;
		else if (pick < 80)
			rq.kind = REQ_LOAD;
		else if (pick < 90)
			rq.kind = REQ_RESTART;
		else
			rq.kind = REQ_UNUSED;
		random_request = rq;
	endfunction

	task automatic push_req(input logic [REQ_BITS-1:0] kind, input logic [IDX_BITS-1:0] idx,
			input logic used, input logic [VALUE_BITS-1:0] lo,
			input logic [VALUE_BITS-1:0] hi, input logic [VALUE_BITS-1:0] start);
		sweep_request_t rq;
		rq.kind = kind;
		rq.index = idx;
		rq.used = used;
		rq.low = lo;
		rq.high = hi;
		rq.start = start;
		request_queue.push_back(rq);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SWEEP_MODE:  mode_q = data[MODE_BITS-1:0];
			REG_TICK_PERIOD: period_q = data[PERIOD_BITS-1:0];
			REG_STEP_SIZE:   step_q = data[STEP_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [MODE_BITS-1:0] mode,
			input logic [PERIOD_BITS-1:0] period, input logic [STEP_BITS-1:0] step);
		write_reg(REG_SWEEP_MODE, CFG_DATA_BITS'(mode));
		write_reg(REG_TICK_PERIOD, CFG_DATA_BITS'(period));
		write_reg(REG_STEP_SIZE, CFG_DATA_BITS'(step));
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// block is idle once nothing is queued, offered or expected
	task automatic wait_drained;
		do
			@(posedge clk);
		while (request_queue.size() != 0 || item_live || expected_reports.size() != 0);
	endtask

	// request driver
	always @(posedge clk) begin : drive_requests
		sweep_request_t rq;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rq.kind = req_type;
				rq.index = entry_index;
				rq.used = entry_used;
				rq.low = range_low;
				rq.high = range_high;
				rq.start = start_value;
				sweep_item(rq);
				item_live = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					rq = request_queue.pop_front();
					req_type <= rq.kind;
					entry_index <= rq.index;
					entry_used <= rq.used;
					range_low <= rq.low;
					range_high <= rq.high;
					start_value <= rq.start;
					in_valid <= 1'b1;
					item_live = 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// report monitor and back-pressure
	always @(posedge clk) begin : check_reports
		entry_report_t want;
		logic          beat;
		int            gap;
		if (arst_n) begin
			beat = out_valid && out_ready;
			if (beat) begin
				beats_seen++;
				if (expected_reports.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected report beat: entry %0d value %h", out_entry, out_value);
				end else begin
					want = expected_reports.pop_front();
					if (out_entry !== want.entry || out_value !== want.value
							|| value_written !== want.written || tick_fired !== want.fired
							|| last_result !== want.last) begin
						error_count++;
						if (error_count <= 10)
							$display("report mismatch: exp entry %0d value %h wr %b fired %b last %b",
								want.entry, want.value, want.written, want.fired, want.last,
								" / got entry %0d value %h wr %b fired %b last %b",
								out_entry, out_value, value_written, tick_fired, last_result);
					end
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (long_hold > 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && beats_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				long_hold = LONG_HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				gap = beat ? pick_gap() : 0;
				if (gap > 0) begin
					rx_stall = gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// stimulus
	initial begin
		clear_table;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// sweeping off: ticks and unknown codes leave everything alone
		push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		push_req(REQ_UNUSED, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(REQ_LOAD, 3'd0, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);
		push_req(REQ_LOAD, 3'd7, 1'b1, 16'hFFFF, 16'h0000, 16'h8000);
		push_req(REQ_LOAD, 3'd3, 1'b0, 16'd100, 16'd200, 16'd150);
		push_req(REQ_LOAD, 3'd5, 1'b1, 16'd1000, 16'd1300, 16'd1200);
		push_req(REQ_RESTART, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		wait_drained;

		// loop up past the top of the value range, low above high
		configure(MODE_LOOP_UP, 16'd0, 8'd255);
		repeat (3) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		wait_drained;

		// once down: entries run below their low bound and stop
		configure(MODE_ONCE_DOWN, 16'd1, 8'd255);
		push_req(REQ_RESTART, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		repeat (4) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		wait_drained;

		// done entries move down outside the once modes, then bounce
		configure(MODE_LOOP_UPDOWN, 16'd0, 8'd200);
		repeat (2) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		push_req(REQ_LOAD, 3'd2, 1'b1, 16'd50, 16'd400, 16'd60);
		push_req(REQ_RESTART, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		repeat (2) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		wait_drained;

		// spare mode: plain wrapping steps
		configure(MODE_RSVD6, 16'd0, 8'd255);
		repeat (2) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		wait_drained;

		// zero step: prescaler fires, nothing written
		configure(MODE_ONCE_UP, 16'd2, 8'd0);
		repeat (3) push_req(REQ_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);

		// random phases: fill the table, restart, then mixed traffic
		for (int ph = 0; ph < 12; ph++) begin
			wait_drained;
			gapless = (ph % 3 == 2);
			case (ph)
				0:  configure(MODE_LOOP_UP, 16'd0, 8'd255);
				1:  configure(MODE_LOOP_DOWN, 16'd1, 8'd17);
				2:  configure(MODE_LOOP_UPDOWN, 16'd0, 8'd1);
				3:  configure(MODE_ONCE_UP, 16'd2, 8'd200);
				4:  configure(MODE_ONCE_DOWN, 16'd0, 8'd64);
				5:  configure(MODE_LOOP_UPDOWN, 16'hFFFF, 8'd9);
				6:  configure(MODE_RSVD6, 16'd0, 8'd50);
				7:  configure(MODE_RSVD7, 16'd3, 8'd0);
				8:  configure(MODE_LOOP_DOWN, 16'd0, 8'd255);
				9:  configure(MODE_ONCE_UP, 16'd0, 8'd255);
				10: configure(MODE_LOOP_UPDOWN, 16'd1, 8'd120);
				default: configure(MODE_OFF, 16'd0, 8'd33);
			endcase
			for (int e = 0; e < ENTRIES; e++)
				request_queue.push_back(random_load(IDX_BITS'(e)));
			if (ph % 4 != 3)
				push_req(REQ_RESTART, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
			repeat (11) request_queue.push_back(random_request());
		end

		wait_drained;
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
